// File: hw/rtl/fifo_with_indexed_insert_core_assert.svh
// Assertion macros used by the checker file.
`ifndef FIFO_WITH_INDEXED_INSERT_CORE_ASSERT_SVH
`define FIFO_WITH_INDEXED_INSERT_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FWII_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define FWII_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed");

`endif

// File: hw/rtl/fwii_pkg.sv
package fwii_pkg;

	// fixed field widths
	localparam int CMD_W    = 2;
	localparam int DATA_W   = 32;
	localparam int POS_W    = 8;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	// command codes
	localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd2;
	localparam logic [CMD_W-1:0] CMD_RSVD   = 2'd3;   // unused, no effect

	// status codes
	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// controller to datapath commands
	typedef struct packed {
		logic load;   // capture the input transaction
		logic exec;   // run the queue operation
	} ctl_t;

endpackage

// File: hw/rtl/fwii_ctrl.sv
module fwii_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	output fwii_pkg::ctl_t ctl
);

	typedef enum logic [1:0] {IDLE, EXEC, RESP} state_t;

	state_t state_q;
	logic   s_tready_q;
	logic   m_tvalid_q;

	// state and handshake registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			s_tready_q <= 1'b1;
			m_tvalid_q <= 1'b0;
		end else begin
			case (state_q)
				IDLE: begin
					if (s_tvalid) begin
						state_q    <= EXEC;
						s_tready_q <= 1'b0;
					end
				end
				EXEC: begin
					state_q    <= RESP;
					m_tvalid_q <= 1'b1;
				end
				RESP: begin
					if (m_tready) begin
						state_q    <= IDLE;
						m_tvalid_q <= 1'b0;
						s_tready_q <= 1'b1;
					end
				end
				default: begin
					state_q    <= IDLE;
					s_tready_q <= 1'b1;
					m_tvalid_q <= 1'b0;
				end
			endcase
		end
	end

	assign s_tready = s_tready_q;
	assign m_tvalid = m_tvalid_q;
	assign ctl.load = s_tvalid & s_tready_q;
	assign ctl.exec = (state_q == EXEC);

endmodule

// File: hw/rtl/fwii_datapath.sv
module fwii_datapath #(
	parameter int QUEUE_DEPTH = 64,
	parameter int ENTRY_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  fwii_pkg::ctl_t                   ctl,
	input  logic [fwii_pkg::CMD_W-1:0]       cmd,
	input  logic [fwii_pkg::DATA_W-1:0]      entry_value,
	input  logic [fwii_pkg::POS_W-1:0]       position,
	output logic [fwii_pkg::STATUS_W-1:0]    status,
	output logic [fwii_pkg::DATA_W-1:0]      popped_value,
	output logic                             popped_valid,
	output logic [fwii_pkg::COUNT_W-1:0]     entry_count
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int WW = (CW > fwii_pkg::POS_W) ? CW : fwii_pkg::POS_W;

	logic [fwii_pkg::CMD_W-1:0]    cmd_q;
	logic [ENTRY_WIDTH-1:0]        value_q;
	logic [fwii_pkg::POS_W-1:0]    pos_q;
	logic [CW-1:0]                 cnt_q;
	logic [ENTRY_WIDTH-1:0]        cell_q [QUEUE_DEPTH];

	logic [fwii_pkg::STATUS_W-1:0] status_q;
	logic [fwii_pkg::DATA_W-1:0]   popped_q;
	logic                          pvalid_q;

	logic [CW-1:0] slot;
	logic          full;
	logic          empty;
	logic          do_ins;
	logic          do_pop;

	assign full   = (cnt_q == CW'(QUEUE_DEPTH));
	assign empty  = (cnt_q == '0);
	assign do_ins = ctl.exec && !full &&
		(cmd_q == fwii_pkg::CMD_PUSH || cmd_q == fwii_pkg::CMD_INSERT);
	assign do_pop = ctl.exec && !empty && (cmd_q == fwii_pkg::CMD_POP);

	// resolve the target slot: the tail for a push; for an insert, clamp from the head, or count back from the tail
	always_comb begin
		logic [WW-1:0] cnt_w;
		logic [WW-1:0] pos_w;
		logic [WW-1:0] back_w;
		logic [fwii_pkg::POS_W-1:0] neg_p;
		neg_p  = ~pos_q;
		cnt_w  = WW'(cnt_q);
		pos_w  = WW'(pos_q);
		back_w = WW'(neg_p);
		if (cmd_q == fwii_pkg::CMD_PUSH) begin
			slot = cnt_q;
		end else if (!pos_q[fwii_pkg::POS_W-1]) begin
			slot = (pos_w < cnt_w) ? CW'(pos_w) : cnt_q;
		end else begin
			slot = (back_w >= cnt_w) ? '0 : CW'(cnt_w - back_w);
		end
	end

	// input capture
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q   <= cmd;
			value_q <= ENTRY_WIDTH'(entry_value);
			pos_q   <= position;
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (do_ins) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (do_pop) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// shift chain: slot 0 is the head
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		localparam int UP = (i == QUEUE_DEPTH - 1) ? i : i + 1;
		localparam int DN = (i == 0) ? 0 : i - 1;
		always_ff @(posedge clk) begin
			if (do_ins) begin
				if (CW'(i) == slot) begin
					cell_q[i] <= value_q;
				end else if (CW'(i) > slot) begin
					cell_q[i] <= cell_q[DN];
				end
			end else if (do_pop) begin
				cell_q[i] <= cell_q[UP];
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			status_q <= fwii_pkg::ST_DONE;
			popped_q <= '0;
			pvalid_q <= 1'b0;
			case (cmd_q)
				fwii_pkg::CMD_PUSH, fwii_pkg::CMD_INSERT: begin
					if (full) begin
						status_q <= fwii_pkg::ST_FULL;
					end
				end
				fwii_pkg::CMD_POP: begin
					if (empty) begin
						status_q <= fwii_pkg::ST_EMPTY;
					end else begin
						popped_q <= fwii_pkg::DATA_W'(cell_q[0]);
						pvalid_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign status       = status_q;
	assign popped_value = popped_q;
	assign popped_valid = pvalid_q;
	assign entry_count  = fwii_pkg::COUNT_W'(cnt_q);

endmodule

// File: hw/rtl/fifo_with_indexed_insert_core.sv
// channel  | dir | tdata (low bit up)                   | tuser (low bit up)
// s_       | in  | entry_value[31:0], position[39:32]   | cmd[1:0]
// m_       | out | popped_value[31:0], entry_count[38:32] | status[1:0], popped_valid[2]
//
// Each command passes through capture, execute (the whole shift chain moves
// together), then result.
// One command is in flight at a time; s_tready stays low until its result is taken.
// A stalled m_tready holds the result and the input.
// Reset clears the count; entry storage needs no clearing.
module fifo_with_indexed_insert_core #(
	parameter int QUEUE_DEPTH = 64,
	parameter int ENTRY_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // entry_value, position
	input  logic [1:0]  s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // popped_value, entry_count, zero pad
	output logic [2:0]  m_tuser    // status, popped_valid
);

	fwii_pkg::ctl_t                   ctl;
	logic [fwii_pkg::STATUS_W-1:0]    status;
	logic [fwii_pkg::DATA_W-1:0]      popped_value;
	logic                             popped_valid;
	logic [fwii_pkg::COUNT_W-1:0]     entry_count;

	fwii_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.ctl      (ctl)
	);

	fwii_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ENTRY_WIDTH (ENTRY_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.cmd          (s_tuser),
		.entry_value  (s_tdata[31:0]),
		.position     (s_tdata[39:32]),
		.status       (status),
		.popped_value (popped_value),
		.popped_valid (popped_valid),
		.entry_count  (entry_count)
	);

	assign m_tdata = {1'b0, entry_count, popped_value};
	assign m_tuser = {popped_valid, status};

endmodule

// File: hw/rtl/fwii_checker.sv
`include "fifo_with_indexed_insert_core_assert.svh"

module fwii_checker #(
	parameter int QUEUE_DEPTH = 64
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [2:0]  m_tuser
);

	`FWII_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))
	`FWII_ASSERT_SAME(a_one_at_a_time, m_tvalid, !s_tready)
	`FWII_ASSERT_SAME(a_pop_is_done, m_tvalid && m_tuser[2], m_tuser[1:0] == fwii_pkg::ST_DONE)
	`FWII_ASSERT_SAME(a_zero_unless_pop, m_tvalid && !m_tuser[2], m_tdata[31:0] == 32'd0)
	`FWII_ASSERT_SAME(a_full_count, m_tvalid && m_tuser[1:0] == fwii_pkg::ST_FULL, m_tdata[38:32] == 7'(QUEUE_DEPTH))

endmodule

bind fifo_with_indexed_insert_core fwii_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
